@@ hw/rtl/balloc_pkg.sv @@
// Shared types and constants for the bump allocator with block table.
// Used by bump_allocator_block_table and its testbench; depends on nothing.
`timescale 1ns / 1ps

package balloc_pkg;

    // Operation codes carried in the mode field.
    localparam logic [2:0] MODE_HEAP_ALLOC = 3'd0;
    localparam logic [2:0] MODE_HEAP_FREE  = 3'd1;
    localparam logic [2:0] MODE_SIZE_QUERY = 3'd2;
    localparam logic [2:0] MODE_PAGE_ALLOC = 3'd3;
    localparam logic [2:0] MODE_PAGE_FREE  = 3'd4;

    // Configuration register indexes.
    localparam logic REG_BASE_ADDR   = 1'b0;
    localparam logic REG_ARENA_LIMIT = 1'b1;

    // Reset values and rounding masks.
    localparam logic [31:0] ARENA_LIMIT_RST = 32'h0100_0000;
    localparam logic [32:0] HEAP_GRAIN_MASK = 33'h0_0000_0007;
    localparam logic [32:0] PAGE_GRAIN_MASK = 33'h0_0000_0FFF;
    localparam logic [31:0] RESULT_FREED    = 32'd1;
    localparam logic [31:0] WORD_SAT        = 32'hFFFF_FFFF;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PAGE_BUMP,
        S_ROUND,
        S_CHECK,
        S_SCAN,
        S_RESP
    } state_t;

    // One block table record as kept in the tag memory.
    typedef struct packed {
        logic        used;
        logic [31:0] addr;
    } tag_t;

endpackage

@@ hw/rtl/bump_allocator_block_table.sv @@
// Top level of the bump allocator with a block table of SLOTS records.
// Depends on balloc_pkg and balloc_ram.
`timescale 1ns / 1ps
//
//  Channel   Signals                              Direction  Contents
//  -------   -----------------------------------  ---------  ---------------------------
//  s_        s_tvalid s_tready s_tdata s_tuser    in         request beat
//  m_        m_tvalid m_tready m_tdata m_tuser    out        result beat
//  cfg_      cfg_valid cfg_ready cfg_index        in         register write
//            cfg_wdata
//
//  After reset a clearing pass walks every slot of the tag memory; no request
//  beat is taken meanwhile, configuration writes are taken at all times.
//  A rejected request or an unknown mode goes straight to the response state,
//  while a page alloc may scan the whole table; the one-slot-per-cycle table
//  scan through the tag memory read port sets how long a request takes.
//  One request is in work at a time; the next beat is taken as soon as the
//  result sits in the output register, even while that result is stalled.

module bump_allocator_block_table #(
    parameter int SLOTS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request: tdata = address[31:0], request_size[63:32]; tuser = mode[2:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    // Result: tdata = result_value[31:0]; tuser = success[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tuser,
    // Register write: index 0 base address, index 1 arena_limit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    import balloc_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    state_t state_reg, state_next;

    logic [31:0] base_addr_reg, arena_limit_reg;
    logic [31:0] bump_reg, bump_next;
    logic [2:0]  mode_reg;
    logic [31:0] addr_reg, size_reg;
    logic [32:0] rounded_reg, rounded_next;
    logic [31:0] new_bump_reg, new_bump_next;
    logic [CNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [31:0] res_value_reg, res_value_next;
    logic        res_ok_reg, res_ok_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_value_reg;
    logic        m_ok_reg;
    logic        out_load;

    // Shared adder and its operands.
    logic [32:0] add_a, add_b;
    logic [33:0] add_sum;

    // Memory ports.
    logic             tag_we, size_we;
    logic [IDX_W-1:0] mem_waddr;
    tag_t             tag_wdata, tag_q;
    logic [31:0]      size_q;

    logic find_free, s_accept, alloc_commit;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_value_reg;
    assign m_tuser   = m_ok_reg;

    assign find_free = (mode_reg == MODE_HEAP_ALLOC) || (mode_reg == MODE_PAGE_ALLOC);
    assign add_sum   = {1'b0, add_a} + {1'b0, add_b};

    // Block table: used mark with address, and recorded size.
    balloc_ram #(.WIDTH($bits(tag_t)), .DEPTH(SLOTS)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (mem_waddr),
        .wdata (tag_wdata),
        .raddr (scan_addr_reg[IDX_W-1:0]),
        .rdata (tag_q)
    );

    balloc_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_size_ram (
        .aclk  (aclk),
        .we    (size_we),
        .waddr (mem_waddr),
        .wdata (size_reg),
        .raddr (scan_addr_reg[IDX_W-1:0]),
        .rdata (size_q)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_addr_reg   <= '0;
            arena_limit_reg <= ARENA_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BASE_ADDR:   base_addr_reg   <= cfg_wdata;
                REG_ARENA_LIMIT: arena_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            bump_reg      <= '0;
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bump_reg      <= bump_next;
            scan_addr_reg <= scan_addr_next;
            rd_pend_reg   <= rd_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= s_tuser;
            addr_reg <= s_tdata[31:0];
            size_reg <= s_tdata[63:32];
        end
        rounded_reg   <= rounded_next;
        new_bump_reg  <= new_bump_next;
        rd_idx_reg    <= rd_idx_next;
        res_value_reg <= res_value_next;
        res_ok_reg    <= res_ok_next;
        if (out_load) begin
            m_value_reg <= res_value_reg;
            m_ok_reg    <= res_ok_reg;
        end
    end

    // Sequencer: next state, adder operands and memory writes.
    always_comb begin
        state_next     = state_reg;
        bump_next      = bump_reg;
        rounded_next   = rounded_reg;
        new_bump_next  = new_bump_reg;
        scan_addr_next = scan_addr_reg;
        rd_pend_next   = rd_pend_reg;
        rd_idx_next    = rd_idx_reg;
        res_value_next = res_value_reg;
        res_ok_next    = res_ok_reg;
        add_a          = '0;
        add_b          = '0;
        tag_we         = 1'b0;
        size_we        = 1'b0;
        mem_waddr      = rd_idx_reg;
        tag_wdata      = '0;
        out_load       = 1'b0;
        alloc_commit   = 1'b0;

        unique case (state_reg)
            // Walk the tag memory once, clearing every used mark.
            S_CLEAR: begin
                tag_we         = 1'b1;
                mem_waddr      = scan_addr_reg[IDX_W-1:0];
                scan_addr_next = scan_addr_reg + CNT_W'(1);
                if (scan_addr_reg == CNT_W'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            // Take a request and route it by mode.
            S_IDLE: begin
                res_value_next = '0;
                res_ok_next    = 1'b0;
                scan_addr_next = '0;
                rd_pend_next   = 1'b0;
                if (s_accept) begin
                    unique case (s_tuser)
                        MODE_HEAP_ALLOC:
                            state_next = (s_tdata[63:32] == '0) ? S_RESP : S_ROUND;
                        MODE_PAGE_ALLOC:
                            state_next = (s_tdata[31:0] != '0 || s_tdata[63:32] == '0)
                                         ? S_RESP : S_PAGE_BUMP;
                        MODE_HEAP_FREE, MODE_PAGE_FREE, MODE_SIZE_QUERY:
                            state_next = S_SCAN;
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end

            // Round the bump offset up to a page, saturating on overflow.
            S_PAGE_BUMP: begin
                add_a = {1'b0, bump_reg};
                add_b = PAGE_GRAIN_MASK;
                bump_next = add_sum[32] ? WORD_SAT : {add_sum[31:12], 12'b0};
                state_next = S_ROUND;
            end

            // Round the requested size to the grain of the mode.
            S_ROUND: begin
                add_a = {1'b0, size_reg};
                if (mode_reg == MODE_PAGE_ALLOC) begin
                    add_b        = PAGE_GRAIN_MASK;
                    rounded_next = add_sum[32:0] & ~PAGE_GRAIN_MASK;
                end else begin
                    add_b        = HEAP_GRAIN_MASK;
                    rounded_next = add_sum[32:0] & ~HEAP_GRAIN_MASK;
                end
                state_next = S_CHECK;
            end

            // Arena check on the exact sum.
            S_CHECK: begin
                add_a         = {1'b0, bump_reg};
                add_b         = rounded_reg;
                new_bump_next = add_sum[31:0];
                if (add_sum <= {2'b0, arena_limit_reg}) begin
                    state_next = S_SCAN;
                end else begin
                    state_next = S_RESP;
                end
            end

            // One slot per cycle; read data arrives in the cycle after its index is issued.
            S_SCAN: begin
                add_a = {1'b0, base_addr_reg};
                add_b = {1'b0, bump_reg};
                if (scan_addr_reg < CNT_W'(SLOTS)) begin
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end else begin
                    rd_pend_next = 1'b0;
                end
                if (rd_pend_reg) begin
                    if (find_free && !tag_q.used) begin
                        tag_we         = 1'b1;
                        size_we        = 1'b1;
                        tag_wdata      = '{used: 1'b1, addr: add_sum[31:0]};
                        bump_next      = new_bump_reg;
                        res_value_next = add_sum[31:0];
                        res_ok_next    = 1'b1;
                        alloc_commit   = 1'b1;
                        state_next     = S_RESP;
                    end else if (!find_free && tag_q.used && tag_q.addr == addr_reg) begin
                        res_ok_next = 1'b1;
                        if (mode_reg == MODE_SIZE_QUERY) begin
                            res_value_next = size_q;
                        end else begin
                            tag_we         = 1'b1;
                            tag_wdata      = '{used: 1'b0, addr: addr_reg};
                            res_value_next = RESULT_FREED;
                        end
                        state_next = S_RESP;
                    end
                end else if (scan_addr_reg == CNT_W'(SLOTS)) begin
                    state_next = S_RESP;
                end
            end

            // Hand the result to the output register once it is free.
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);
    end

    // An allocation never moves the bump offset past the arena limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        alloc_commit |-> new_bump_reg <= arena_limit_reg)
        else $error("allocation committed beyond arena limit");

    // An accepted request always leaves the idle state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg != S_IDLE)
        else $error("request accepted without starting work");

    // The tag memory is never written while waiting for a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tag_we |-> state_reg != S_IDLE && state_reg != S_RESP)
        else $error("tag write outside clearing or scan");

    // A new result appears only out of the response state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_RESP))
        else $error("result beat raised outside response state");

endmodule

@@ hw/rtl/balloc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; instanced for the block table memories.
`timescale 1ns / 1ps

module balloc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ verif/balloc_result_checker.sv @@
// Result checker for the bump allocator block table testbench.
// Watches the request, result and register channels; depends on balloc_pkg.
`timescale 1ns / 1ps

module balloc_result_checker #(
    parameter int SLOTS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,          // address[31:0], request_size[63:32]
    input  logic [2:0]  s_tuser,          // mode[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,          // result_value[31:0]
    input  logic        m_tuser,          // success[0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          mismatch_count,
    output int          results_pending
);
    import balloc_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        ok;
    } outcome_t;

    // Mirror of the allocator state and its registers.
    logic [31:0] base_addr;
    logic [31:0] limit_bytes;
    logic [31:0] bump;
    logic        blk_used [SLOTS];
    logic [31:0] blk_addr [SLOTS];
    logic [31:0] blk_size [SLOTS];

    // Outcomes of accepted requests whose result beat has not arrived yet.
    outcome_t    awaited [$];

    function automatic int first_free_block();
        for (int i = 0; i < SLOTS; i++)
            if (!blk_used[i])
                return i;
        return -1;
    endfunction

    function automatic int first_block_at(logic [31:0] target);
        for (int i = 0; i < SLOTS; i++)
            if (blk_used[i] && blk_addr[i] == target)
                return i;
        return -1;
    endfunction

    // Takes the lowest free record when the rounded span still fits in the arena.
    // The end offset is formed wide so that it never wraps.
    function automatic outcome_t claim_block(logic [31:0] size, logic [32:0] span);
        outcome_t    res;
        int          slot;
        logic [33:0] end_off;
        res     = '0;
        slot    = first_free_block();
        end_off = {2'b00, bump} + {1'b0, span};
        if (end_off <= {2'b00, limit_bytes} && slot >= 0) begin
            res.value      = base_addr + bump;
            res.ok         = 1'b1;
            bump           = end_off[31:0];
            blk_used[slot] = 1'b1;
            blk_addr[slot] = res.value;
            blk_size[slot] = size;
        end
        return res;
    endfunction

    // Applies one request to the mirror and returns the result it must produce.
    function automatic outcome_t apply_request(logic [2:0] mode, logic [31:0] target,
                                               logic [31:0] size);
        outcome_t    res;
        logic [32:0] aligned;
        int          slot;
        res = '0;
        case (mode)
            MODE_HEAP_ALLOC: begin
                if (size != 0)
                    res = claim_block(size, ({1'b0, size} + HEAP_GRAIN_MASK) & ~HEAP_GRAIN_MASK);
            end
            MODE_PAGE_ALLOC: begin
                // The offset keeps its page alignment even when the request fails.
                if (target == 0 && size != 0) begin
                    aligned = ({1'b0, bump} + PAGE_GRAIN_MASK) & ~PAGE_GRAIN_MASK;
                    bump    = aligned[32] ? WORD_SAT : aligned[31:0];
                    res     = claim_block(size,
                                          ({1'b0, size} + PAGE_GRAIN_MASK) & ~PAGE_GRAIN_MASK);
                end
            end
            MODE_HEAP_FREE, MODE_PAGE_FREE: begin
                slot = first_block_at(target);
                if (slot >= 0) begin
                    blk_used[slot] = 1'b0;
                    res.value      = RESULT_FREED;
                    res.ok         = 1'b1;
                end
            end
            MODE_SIZE_QUERY: begin
                slot = first_block_at(target);
                if (slot >= 0) begin
                    res.value = blk_size[slot];
                    res.ok    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Register writes first, then the result beat against the oldest outcome,
    // then the new request beat.
    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            base_addr      = '0;
            limit_bytes    = ARENA_LIMIT_RST;
            bump           = '0;
            mismatch_count = 0;
            foreach (blk_used[i])
                blk_used[i] = 1'b0;
            awaited.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BASE_ADDR:   base_addr   = cfg_wdata;
                    REG_ARENA_LIMIT: limit_bytes = cfg_wdata;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual value %h success %b",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = awaited.pop_front();
                    if (m_tdata !== want.value) begin
                        $display("%0t: result_value mismatch, expected %h, actual %h",
                                 $time, want.value, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.ok) begin
                        $display("%0t: success mismatch, expected %b, actual %b",
                                 $time, want.ok, m_tuser);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited.push_back(apply_request(s_tuser, s_tdata[31:0], s_tdata[63:32]));
        end
        results_pending = awaited.size();
    end

endmodule

@@ verif/bump_allocator_block_table_test.sv @@
// Testbench top for the bump allocator with block table: clock, reset, stimulus, verdict.
// Depends on balloc_pkg, bump_allocator_block_table and balloc_result_checker.
`timescale 1ns / 1ps

module bump_allocator_block_table_test;
    import balloc_pkg::*;

    localparam int SLOTS            = 256;
    localparam int CLK_HALF         = 10;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = SLOTS + 16;
    localparam int POOL_DEPTH       = 512;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;           // address[31:0], request_size[63:32]
    logic [2:0]  s_tuser;           // mode[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;           // result_value[31:0]
    logic        m_tuser;           // success[0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    int          mismatch_count;
    int          results_pending;
    int          cycle_count  = 0;
    bit          quiet_mode   = 1'b0;
    bit          hold_request = 1'b0;

    // Addresses handed back by the block, reused so that frees and queries hit.
    logic [31:0] live_addrs [$];

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk)
        cycle_count <= cycle_count + 1;

    bump_allocator_block_table #(
        .SLOTS(SLOTS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    balloc_result_checker #(
        .SLOTS(SLOTS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Collect successful results whose value is not RESULT_FREED (allocations and size queries alike) as candidates.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready && m_tuser && m_tdata != RESULT_FREED) begin
            live_addrs.push_back(m_tdata);
            if (live_addrs.size() > POOL_DEPTH)
                void'(live_addrs.pop_front());
        end
    end

    // Result side: short random stalls, one long hold-off on request, none when quiet.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet_mode && (cycle_count / 160) % 3 != 1 &&
                         $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Request side gap, skipped in calm windows and when quiet.
    task automatic maybe_pause_requests();
        if (!quiet_mode && (cycle_count / 160) % 3 != 0 && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    // Offers one request beat and returns at the falling edge after it is taken.
    task automatic send_request(logic [2:0] mode, logic [31:0] target, logic [31:0] size);
        maybe_pause_requests();
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {size, target};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge aclk);
    endtask

    task automatic write_register(logic index, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(logic [31:0] base, logic [31:0] limit);
        wait_for_results();
        write_register(REG_BASE_ADDR, base);
        write_register(REG_ARENA_LIMIT, limit);
    endtask

    // Mostly small sizes, some page-sized and larger, a few zero or full-range.
    function automatic logic [31:0] random_size(bit only_small);
        int pick;
        pick = $urandom_range(0, 99);
        if (only_small)
            return $urandom_range(1, 64);
        if (pick < 2)
            return '0;
        if (pick < 60)
            return $urandom_range(1, 64);
        if (pick < 85)
            return $urandom_range(1, 8192);
        if (pick < 95)
            return $urandom_range(1, 1 << 20);
        return $urandom();
    endfunction

    // One random request: allocs, frees and queries by percentage, a few unknown modes.
    task automatic send_random(int alloc_pct, int free_pct, bit only_small);
        int          pick;
        int          idx;
        logic [2:0]  mode;
        logic [31:0] target;
        pick   = $urandom_range(0, 99);
        target = $urandom();
        if (pick < alloc_pct) begin
            mode = ($urandom_range(0, 2) == 0) ? MODE_PAGE_ALLOC : MODE_HEAP_ALLOC;
            if (mode == MODE_PAGE_ALLOC && $urandom_range(0, 9) != 0)
                target = '0;
            send_request(mode, target, random_size(only_small));
        end else if (pick < 97) begin
            if (pick < alloc_pct + free_pct)
                mode = $urandom_range(0, 1) ? MODE_HEAP_FREE : MODE_PAGE_FREE;
            else
                mode = MODE_SIZE_QUERY;
            if (live_addrs.size() != 0 && $urandom_range(0, 6) != 0) begin
                idx    = $urandom_range(0, live_addrs.size() - 1);
                target = live_addrs[idx];
                if (mode != MODE_SIZE_QUERY)
                    live_addrs.delete(idx);
            end
            send_request(mode, target, $urandom());
        end else begin
            send_request(MODE_PAGE_FREE + 3'($urandom_range(1, 3)), target, $urandom());
        end
    endtask

    // Run limit, several times the slowest legal run.
    initial begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Main stimulus.
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE_ADDR;
        cfg_wdata = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: zero base, tiny arena so the limit is reached exactly.
        configure(32'h0000_0000, 32'h0000_4000);
        send_request(MODE_HEAP_ALLOC, 32'h0, 32'd0);
        send_request(MODE_HEAP_ALLOC, 32'h0, 32'd1);            // success at address zero
        send_request(MODE_HEAP_ALLOC, 32'hFFFF_FFFF, 32'd8);
        send_request(MODE_SIZE_QUERY, 32'h0, 32'h0);
        send_request(MODE_SIZE_QUERY, 32'h8, 32'hFFFF_FFFF);
        send_request(MODE_SIZE_QUERY, 32'h4, 32'h0);
        send_request(MODE_HEAP_FREE, 32'h8, 32'h0);
        send_request(MODE_HEAP_FREE, 32'h8, 32'h0);
        send_request(MODE_PAGE_ALLOC, 32'hFFFF_FFFF, 32'd4096);  // nonzero requested address
        send_request(MODE_PAGE_ALLOC, 32'h0, 32'd0);
        send_request(MODE_PAGE_ALLOC, 32'h0, 32'd1);            // offset aligns up to a page
        send_request(MODE_PAGE_FREE, 32'h1000, 32'h0);
        send_request(MODE_PAGE_FREE, 32'h1000, 32'h0);
        send_request(MODE_PAGE_FREE + 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_PAGE_FREE + 3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_PAGE_FREE + 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_HEAP_ALLOC, 32'h0, 32'hFFFF_FFFF);     // sum passes 32 bits
        send_request(MODE_PAGE_ALLOC, 32'h0, 32'hFFFF_FFFF);
        send_request(MODE_HEAP_ALLOC, 32'h0, 32'h0000_2000);     // ends exactly on the limit
        send_request(MODE_HEAP_ALLOC, 32'h0, 32'd1);
        send_request(MODE_PAGE_ALLOC, 32'h0, 32'd1);
        send_request(MODE_HEAP_FREE, 32'h0, 32'h0);
        send_request(MODE_SIZE_QUERY, 32'h0, 32'h0);

        // Base near the top so returned addresses wrap; long result stall early on.
        configure(32'hFFFF_F000, ARENA_LIMIT_RST);
        hold_request = 1'b1;
        repeat (500) send_random(40, 30, 1'b0);

        // Allocation-heavy with small sizes until the table is full.
        configure($urandom(), 32'h1000_0000);
        repeat (350) send_random(85, 5, 1'b1);

        // Zero arena: every allocation fails, frees drain the table.
        configure(32'h0000_0000, 32'h0000_0000);
        repeat (100) send_random(30, 40, 1'b0);

        // All-ones base with a moderate arena.
        configure(32'hFFFF_FFFF, 32'h0300_0000);
        repeat (500) send_random(45, 35, 1'b0);

        // Last part without idling: full arena, fill the offset to the top,
        // then a page alloc whose alignment no longer fits in 32 bits.
        configure(32'h0000_0000, 32'hFFFF_FFFF);
        quiet_mode = 1'b1;
        repeat (60) send_random(0, 97, 1'b0);
        for (int k = 31; k >= 3; k--)
            send_request(MODE_HEAP_ALLOC, $urandom(), 32'd1 << k);
        send_request(MODE_PAGE_ALLOC, 32'h0, 32'd1);
        send_request(MODE_HEAP_ALLOC, 32'h0, 32'd1);
        repeat (150) send_random(30, 40, 1'b0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
